// File: sv/jrt_pkg.sv
`default_nettype none
package jrt_pkg;

   localparam int TABLE_DEPTH = 64;

   // request function codes
   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_CHECK = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   // add status codes
   localparam logic [1:0] ST_UPDATED  = 2'd0;
   localparam logic [1:0] ST_INSERTED = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] block_number;
      logic [31:0] position;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       revoked;
   } rsp_type;

   // request in flight along the cell chain
   typedef struct packed {
      logic    valid;
      logic    done;
      req_type req;
      rsp_type rsp;
   } token_type;

endpackage
`default_nettype wire

// File: sv/jrt_cell.sv
`default_nettype none
module jrt_cell (
   input  wire               clock,
   input  wire               reset,
   input  wire               shift,
   input  wire        [31:0] replay_tail,
   input  jrt_pkg::token_type tok_in,
   output jrt_pkg::token_type tok_out
);
   import jrt_pkg::*;

   logic [63:0] entry_block_ff;
   logic [31:0] entry_position_ff;
   logic        entry_valid_ff;
   logic        entry_valid_in;
   logic        entry_write;
   logic        pos_write;
   token_type   tok_ff;
   token_type   tok_in_next;
   logic        match;
   logic        wraps;
   logic        after_tail;
   logic        before_end;
   logic        hit;

   assign match      = entry_valid_ff && (entry_block_ff == tok_in.req.block_number);
   assign wraps      = entry_position_ff < replay_tail;
   assign after_tail = replay_tail < tok_in.req.position;
   assign before_end = tok_in.req.position < entry_position_ff;
   assign hit        = wraps ? (after_tail || before_end) : (after_tail && before_end);

   always_comb begin
      tok_in_next    = tok_in;
      entry_valid_in = entry_valid_ff;
      entry_write    = 1'b0;
      pos_write      = 1'b0;
      if (tok_in.valid) begin
         case (tok_in.req.func)
            FUNC_ADD: begin
               if (!tok_in.done && match) begin
                  pos_write              = 1'b1;
                  tok_in_next.done       = 1'b1;
                  tok_in_next.rsp.status = ST_UPDATED;
               end else if (!tok_in.done && !entry_valid_ff) begin
                  // valid entries form a prefix, so no match can lie further on
                  entry_write            = 1'b1;
                  pos_write              = 1'b1;
                  entry_valid_in         = 1'b1;
                  tok_in_next.done       = 1'b1;
                  tok_in_next.rsp.status = ST_INSERTED;
               end
            end
            FUNC_CHECK: begin
               if (!tok_in.done && match) begin
                  tok_in_next.done        = 1'b1;
                  tok_in_next.rsp.revoked = hit;
               end
            end
            FUNC_CLEAR: begin
               entry_valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (shift) begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift && entry_write) begin
         entry_block_ff <= tok_in.req.block_number;
      end
      if (shift && pos_write) begin
         entry_position_ff <= tok_in.req.position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (shift) begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

// File: sv/journal_revoke_table_unit.sv
// journal revoke table: a chain of TABLE_DEPTH cells, one table entry each.
// req channel (req_valid/req_ready, req_data): func add, check or clear, a
// block number and a journal position. rsp channel (rsp_valid/rsp_ready,
// rsp_data): status for an add, revoked flag for a check, one per request.
// csr_we/csr_wdata write replay_tail, the start of the circular window;
// write it only while no request is in flight.
// a request enters a stage register, then walks one cell per cycle while
// no response stalls, and its response comes out of the last cell.
// one request walks toward the last cell at a time: req_ready rises again
// as the response lands in the last cell, so the next request is taken
// only once the one before it has reached the last cell.
// a stalled response freezes the whole chain until it is taken; one more
// request can be taken into the stage register and waits there.
// reset empties the table and the chain and sets replay_tail to zero;
// req_ready stays low while reset is high.
`default_nettype none
module journal_revoke_table_unit (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  jrt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output jrt_pkg::rsp_type rsp_data,
   input  wire              csr_we,
   input  wire       [31:0] csr_wdata
);
   import jrt_pkg::*;

   token_type                tok [0:TABLE_DEPTH];
   logic [TABLE_DEPTH:0]     tok_vld;
   token_type                tok0_ff;
   token_type                tok0_in;
   logic                     busy_ff;
   logic                     busy_in;
   logic [31:0]              replay_tail_ff;
   logic                     shift;
   logic                     accept;

   assign rsp_valid = tok[TABLE_DEPTH].valid;
   assign rsp_data  = tok[TABLE_DEPTH].rsp;
   assign shift     = !rsp_valid || rsp_ready;
   assign req_ready = !busy_ff && !reset;
   assign accept    = req_valid && req_ready;

   always_comb begin
      tok0_in             = tok0_ff;
      tok0_in.valid       = 1'b1;
      tok0_in.done        = 1'b0;
      tok0_in.req         = req_data;
      tok0_in.rsp.revoked = 1'b0;
      // an add that never finds a slot leaves the chain as full
      tok0_in.rsp.status  = (req_data.func == FUNC_ADD) ? ST_FULL : ST_UPDATED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok0_ff.valid <= 1'b0;
      end else if (accept) begin
         tok0_ff <= tok0_in;
      end else if (shift) begin
         tok0_ff.valid <= 1'b0;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (shift && tok_vld[TABLE_DEPTH-1]) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         replay_tail_ff <= 32'd0;
      end else begin
         busy_ff <= busy_in;
         if (csr_we) begin
            replay_tail_ff <= csr_wdata;
         end
      end
   end

   assign tok[0] = tok0_ff;

   genvar i;
   generate
      for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
         jrt_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift       (shift),
            .replay_tail (replay_tail_ff),
            .tok_in      (tok[i]),
            .tok_out     (tok[i+1])
         );
      end
      for (i = 0; i <= TABLE_DEPTH; i++) begin : g_vld
         assign tok_vld[i] = tok[i].valid;
      end
   endgenerate

   // never more than one request walking toward the output
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vld[TABLE_DEPTH-1:0]))
      else $error("more than one request in the cell chain");

   // when not busy the cells before the output hold no request
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (tok_vld[TABLE_DEPTH-1:0] == '0))
      else $error("request in chain while idle");

   // a stalled response freezes the chain
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && !accept) |=> $stable(tok_vld))
      else $error("chain moved during response stall");

   // an accepted request sets busy and lands in the stage register
   a_busy_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && tok_vld[0])
      else $error("accepted request not in stage register");

endmodule
`default_nettype wire

// File: dv/tb_journal_revoke_table_unit.sv
`timescale 1ns / 100ps

class revoke_scoreboard;
   logic [63:0] blk_tab[jrt_pkg::TABLE_DEPTH];
   logic [31:0] pos_tab[jrt_pkg::TABLE_DEPTH];
   bit          vld_tab[jrt_pkg::TABLE_DEPTH];
   logic [31:0] tail;
   jrt_pkg::rsp_type expected_q[$];
   int mismatches;
   int n_requests;
   int n_inserted;
   int n_updated;
   int n_full;
   int n_checks;
   int n_revoked;
   int n_clears;
   int n_tails;

   function new();
      tail = '0;
      foreach (vld_tab[i]) vld_tab[i] = 1'b0;
   endfunction

   function void set_tail(input logic [31:0] value);
      tail = value;
      n_tails++;
   endfunction

   function int find_block(input logic [63:0] blk);
      for (int i = 0; i < jrt_pkg::TABLE_DEPTH; i++)
         if (vld_tab[i] && blk_tab[i] == blk) return i;
      return -1;
   endfunction

   function int find_free();
      for (int i = 0; i < jrt_pkg::TABLE_DEPTH; i++)
         if (!vld_tab[i]) return i;
      return -1;
   endfunction

   function bit stored_position(input logic [63:0] blk, output logic [31:0] pos);
      int idx;
      idx = find_block(blk);
      pos = (idx >= 0) ? pos_tab[idx] : '0;
      return idx >= 0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void note_request(input jrt_pkg::req_type r);
      jrt_pkg::rsp_type e;
      int               idx;
      logic [31:0]      stored;
      bit               wraps;
      bit               after_tail;
      bit               before_end;
      e = '0;
      n_requests++;
      case (r.func)
         jrt_pkg::FUNC_ADD: begin
            idx = find_block(r.block_number);
            if (idx >= 0) begin
               pos_tab[idx] = r.position;
               e.status = jrt_pkg::ST_UPDATED;
               n_updated++;
            end else begin
               idx = find_free();
               if (idx >= 0) begin
                  blk_tab[idx] = r.block_number;
                  pos_tab[idx] = r.position;
                  vld_tab[idx] = 1'b1;
                  e.status = jrt_pkg::ST_INSERTED;
                  n_inserted++;
               end else begin
                  e.status = jrt_pkg::ST_FULL;
                  n_full++;
               end
            end
         end
         jrt_pkg::FUNC_CHECK: begin
            n_checks++;
            idx = find_block(r.block_number);
            if (idx >= 0) begin
               stored = pos_tab[idx];
               // window runs from tail to stored position, bounds excluded
               wraps = stored < tail;
               after_tail = tail < r.position;
               before_end = r.position < stored;
               e.revoked = wraps ? (after_tail || before_end) : (after_tail && before_end);
               if (e.revoked) n_revoked++;
            end
         end
         jrt_pkg::FUNC_CLEAR: begin
            foreach (vld_tab[i]) vld_tab[i] = 1'b0;
            n_clears++;
         end
         default: begin
         end
      endcase
      expected_q.push_back(e);
   endfunction

   function void check_response(input jrt_pkg::rsp_type got);
      jrt_pkg::rsp_type e;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response: status %0d revoked %0b", got.status, got.revoked);
         return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status || got.revoked !== e.revoked) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: status exp %0d got %0d, revoked exp %0b got %0b",
                     e.status, got.status, e.revoked, got.revoked);
      end
   endfunction
endclass

module tb_journal_revoke_table_unit;
   import jrt_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int STALL_LIMIT = 4000;
   localparam int CHUNK_ITEMS = 255;
   localparam int SETTLE_CYCLES = 130;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   int send_idle = 0;
   int recv_idle = 0;
   bit holdoff_req = 1'b0;
   int stall_cycles = 0;

   revoke_scoreboard sb = new();

   journal_revoke_table_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // receiver: random back-pressure plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (holdoff_req) begin
            holdoff_req = 1'b0;
            hold_left = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no request or response moved for %0d cycles", stall_cycles);
         $display("tb_journal_revoke_table_unit: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic req_type mk(input logic [1:0] func, input logic [63:0] blk,
                                  input logic [31:0] pos);
      req_type r;
      r.func = func;
      r.block_number = blk;
      r.position = pos;
      return r;
   endfunction

   // positions cluster on the window bounds so the edge cases get hit often
   function automatic logic [31:0] pick_position(input bit have, input logic [31:0] stored);
      logic [31:0] s;
      s = have ? stored : $urandom;
      case ($urandom_range(11))
         0: return sb.tail;
         1: return sb.tail + 32'd1;
         2: return sb.tail - 32'd1;
         3: return s - 32'd1;
         4: return s;
         5: return s + 32'd1;
         6: return '0;
         7: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input req_type r, inout int count);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
      if (r.func != FUNC_UNUSED) count++;
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_tail(input logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_tail(value);
   endtask

   task automatic run_directed(inout int count);
      logic [63:0] pat;
      pat = 64'h5555_5555_5555_5555;
      send_request(mk(FUNC_CHECK, 64'd5, 32'd10), count);          // empty table
      send_request(mk(FUNC_ADD, 64'd0, 32'd50), count);            // stored below tail
      send_request(mk(FUNC_ADD, '1, 32'd200), count);
      send_request(mk(FUNC_ADD, 64'd0, 32'd60), count);            // update in place
      send_request(mk(FUNC_CHECK, 64'd0, 32'd30), count);
      send_request(mk(FUNC_CHECK, 64'd0, 32'd60), count);
      send_request(mk(FUNC_CHECK, 64'd0, 32'd100), count);
      send_request(mk(FUNC_CHECK, 64'd0, 32'd101), count);
      send_request(mk(FUNC_CHECK, 64'd0, '1), count);
      send_request(mk(FUNC_CHECK, 64'd0, 32'd80), count);
      send_request(mk(FUNC_CHECK, '1, 32'd150), count);
      send_request(mk(FUNC_CHECK, '1, 32'd100), count);
      send_request(mk(FUNC_CHECK, '1, 32'd200), count);
      send_request(mk(FUNC_CHECK, '1, '0), count);
      send_request(mk(FUNC_UNUSED, '1, '1), count);
      send_request(mk(FUNC_ADD, pat, 32'd100), count);             // stored equals tail
      send_request(mk(FUNC_CHECK, pat, 32'd100), count);
      send_request(mk(FUNC_CHECK, ~pat, 32'd120), count);
      send_request(mk(FUNC_CLEAR, '0, '0), count);
      send_request(mk(FUNC_CHECK, 64'd0, 32'd30), count);          // gone after clear
      send_request(mk(FUNC_ADD, 64'd0, '1), count);
      send_request(mk(FUNC_CHECK, 64'd0, '0), count);
      send_request(mk(FUNC_CHECK, 64'd0, 32'hFFFF_FFFE), count);
   endtask

   task automatic run_chunk(input int n_items, input bit big_pool, inout int total);
      logic [63:0] pool[128];
      int          psize;
      int          done_items;
      int          roll;
      logic [63:0] b;
      logic [31:0] p;
      logic [31:0] s;
      bit          have;
      logic [1:0]  f;
      psize = big_pool ? 100 : 24;
      foreach (pool[i]) pool[i] = {$urandom, $urandom};
      pool[1] = '0;
      pool[2] = '1;
      done_items = 0;
      send_request(mk(FUNC_CLEAR, {$urandom, $urandom}, $urandom), done_items);
      // fill past capacity so the full status shows up
      if (big_pool)
         for (int i = 0; i < TABLE_DEPTH + 6; i++)
            send_request(mk(FUNC_ADD, pool[i], pick_position(1'b0, '0)), done_items);
      while (done_items < n_items) begin
         roll = $urandom_range(99);
         b = ($urandom_range(99) < 85) ? pool[$urandom_range(psize - 1)]
                                       : {$urandom, $urandom};
         have = sb.stored_position(b, s);
         p = pick_position(have, s);
         if (roll < 1) f = FUNC_CLEAR;
         else if (roll < 3) f = FUNC_UNUSED;
         else if (roll < 50) f = FUNC_ADD;
         else f = FUNC_CHECK;
         send_request(mk(f, b, p), done_items);
      end
      total += done_items;
   endtask

   initial begin
      int          total;
      logic [31:0] tail_val;
      total = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle = 27;
      recv_idle = 56;
      write_tail(32'd100);
      run_directed(total);

      for (int c = 0; c < 6; c++) begin
         drain_responses();
         case (c)
            0: tail_val = '0;
            1: tail_val = '1;
            2: tail_val = 32'h8000_0000;
            4: tail_val = 32'd1;
            default: tail_val = $urandom;
         endcase
         write_tail(tail_val);
         if (c < 2) begin
            send_idle = 27;
            recv_idle = 56;
         end else if (c < 4) begin
            send_idle = 56;
            recv_idle = 27;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         if (c == 4) begin
            @(posedge clock);
            holdoff_req = 1'b1;
         end
         run_chunk(CHUNK_ITEMS, (c % 2) == 0, total);
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d requests under %0d replay_tail settings: %0d inserts, %0d updates,",
               sb.n_requests, sb.n_tails, sb.n_inserted, sb.n_updated);
      $display("  %0d table-full adds, %0d of %0d checks revoked, %0d clears, %0d mismatches",
               sb.n_full, sb.n_revoked, sb.n_checks, sb.n_clears, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb_journal_revoke_table_unit: done, clean");
      end else begin
         $display("tb_journal_revoke_table_unit: done, errors");
      end
      $finish;
   end
endmodule
